FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the baud calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, held off while reset is asserted.
`define UBV_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define UBV_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ubv_pkg.sv
// Shared types and constants of the baud value calculator.
package ubv_pkg;

  localparam int unsigned BAUD_W   = 24;
  localparam int unsigned CLK_W    = 32;
  localparam int unsigned OVS_W    = 5;
  localparam int unsigned PROD_W   = BAUD_W + OVS_W;
  localparam int unsigned REM_W    = CLK_W + 1;
  localparam int unsigned VALUE_W  = 16;

  localparam logic [VALUE_W-1:0] BAUD_MAX = '1;

  // Data handed from cell to cell along the divider row.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [CLK_W-1:0] div;
    logic             err;
  } ubv_data_t;

endpackage

FILE: rtl/core/uart_baud_value_calculator.sv
// Top level of the fractional UART baud register calculator.
//
// Input stream (s_axis): one transfer per request, carrying the wanted baud
// rate, the reference clock in hertz and the oversampling count.
// Output stream (m_axis): one transfer per request, in request order, with
// the 16-bit baud register value 65536 * (1 - samples * baud / clock) and a
// range error flag. A zero clock, or samples * baud above the clock, gives
// the flag and a value of zero.
//
// The pipeline has one input stage that forms the product and the range
// check, FRACTION_BITS + 1 divider cells that each settle one quotient bit,
// and one output stage. Throughput is one request per cycle while the
// receiver takes results: the row of cells is a pipeline, each cell
// holding one request, so the rate is set by a single 33-bit trial
// subtract per cell.
//
// Reset clears every valid flag; the pipeline is empty afterwards.
// When the receiver stalls, each stage holds its request while free stages
// further up keep filling, so s_axis_tready falls only once every stage is
// occupied.
module uart_baud_value_calculator #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // baud_rate [23:0], clock_hz [55:24], oversampling [60:56], zeros [63:61]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // baud_reg [15:0]
  output logic [15:0] m_axis_tdata,
  // range_error [0]
  output logic [0:0]  m_axis_tuser
);
  import ubv_pkg::*;

  localparam int unsigned NCELL = FRACTION_BITS + 1;
  localparam int unsigned QW    = FRACTION_BITS + 1;

  // Handshake and data between stages; index 0 is the input stage output.
  logic                 valid [NCELL+1];
  logic                 ready [NCELL+1];
  ubv_data_t            data  [NCELL+1];
  logic [QW-1:0]        quo   [NCELL+1];
  logic [VALUE_W-1:0]   value;
  logic                 err;

  ubv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .baud_i  (s_axis_tdata[BAUD_W-1:0]),
    .clock_i (s_axis_tdata[BAUD_W+CLK_W-1:BAUD_W]),
    .ovs_i   (s_axis_tdata[BAUD_W+CLK_W+OVS_W-1:BAUD_W+CLK_W]),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .data_o  (data[0])
  );

  // Quotient starts empty; each cell shifts in one bit, most significant first.
  assign quo[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ubv_cell #(
      .QW (QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .data_i  (data[i]),
      .quo_i   (quo[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .data_o  (data[i+1]),
      .quo_o   (quo[i+1])
    );
  end

  ubv_out #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NCELL]),
    .ready_o (ready[NCELL]),
    .quo_i   (quo[NCELL]),
    .err_i   (data[NCELL].err),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .value_o (value),
    .err_o   (err)
  );

  assign m_axis_tdata    = value;
  assign m_axis_tuser[0] = err;

endmodule

FILE: rtl/core/ubv_front.sv
// Input stage: forms samples times baud and flags requests out of range.
module ubv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [ubv_pkg::BAUD_W-1:0] baud_i,
  input  logic [ubv_pkg::CLK_W-1:0]  clock_i,
  input  logic [ubv_pkg::OVS_W-1:0]  ovs_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output ubv_pkg::ubv_data_t       data_o
);
  import ubv_pkg::*;

  logic              valid_q;
  ubv_data_t         data_q, data_d;
  logic [PROD_W-1:0] prod;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod        = PROD_W'(ovs_i) * PROD_W'(baud_i);
    data_d.rem  = REM_W'(prod);
    data_d.div  = clock_i;
    data_d.err  = (clock_i == '0) || (CLK_W'(prod) > clock_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/ubv_cell.sv
// One divider cell: trial subtract, keep one quotient bit, shift the remainder on.
module ubv_cell #(
  parameter int unsigned QW = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ubv_pkg::ubv_data_t data_i,
  input  logic [QW-1:0]      quo_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ubv_pkg::ubv_data_t data_o,
  output logic [QW-1:0]      quo_o
);
  import ubv_pkg::*;

  logic             valid_q;
  ubv_data_t        data_q, data_d;
  logic [QW-1:0]    quo_q, quo_d;
  logic [REM_W:0]   diff;
  logic             take;
  logic [REM_W-1:0] kept;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    diff        = {1'b0, data_i.rem} - {2'b00, data_i.div};
    take        = !diff[REM_W];
    kept        = take ? diff[REM_W-1:0] : data_i.rem;
    // In range, the remainder is below the divisor, so the shift loses no bit.
    data_d.rem  = {kept[CLK_W-1:0], 1'b0};
    data_d.div  = data_i.div;
    data_d.err  = data_i.err;
    quo_d       = {quo_i[QW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign quo_o   = quo_q;

endmodule

FILE: rtl/core/ubv_out.sv
// Output stage: turns the quotient into the saturated baud register value.
module ubv_out #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [FRACTION_BITS:0]      quo_i,
  input  logic                        err_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [ubv_pkg::VALUE_W-1:0] value_o,
  output logic                        err_o
);
  import ubv_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                   valid_q;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic                   err_q;
  logic [FRACTION_BITS:0] scale;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    scale = ONE - quo_i;
    if (err_i) begin
      value_d = '0;
    end else if (scale[FRACTION_BITS]) begin
      value_d = BAUD_MAX;
    end else begin
      value_d = scale[FRACTION_BITS-1 -: VALUE_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      value_q <= value_d;
      err_q   <= err_i;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign err_o   = err_q;

endmodule

FILE: rtl/core/ubv_checker.sv
// Port-level checks of the baud value calculator, bound to the top level.
`include "assert_macros.svh"

module ubv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Input backs up only when every stage is full and the receiver stalls.
  `UBV_ASSERT(a_backpressure, clk_i, rst_ni,
              !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
              "input stalled while pipeline had room")

  // An error result always carries a zero value.
  `UBV_ASSERT(a_err_zero, clk_i, rst_ni,
              (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 16'h0000),
              "range error with non-zero value")

  // A stalled result stays offered.
  `UBV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `UBV_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "result changed while stalled")

endmodule

bind uart_baud_value_calculator ubv_checker u_ubv_checker (.*);
